// ----- rtl/sorted_byte_list_insert_delete_defines.svh -----
// assertion macros for the sorted byte list
`ifndef SORTED_BYTE_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_BYTE_LIST_INSERT_DELETE_DEFINES_SVH

// same-cycle implication
`define SBL_ASSERT_NOW(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error("sorted byte list check failed");

// next-cycle implication
`define SBL_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error("sorted byte list check failed");

`endif

// ----- rtl/sbl_pkg.sv -----
// shared types and codes for the sorted byte list
package sbl_pkg;

	localparam int DEPTH_DEF = 16;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_DELETE = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_DELETED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// broadcast to every cell
	typedef struct packed {
		logic              ins;
		logic              del;
		logic signed [7:0] value;
	} cell_op_t;

endpackage

// ----- rtl/sorted_byte_list_insert_delete.sv -----
// top level of the sorted signed-byte list with insert and delete
//
// keeps up to DEPTH signed bytes in ascending order, duplicates allowed
// input channel (in_valid/in_ready): one beat is one operation, mode 0
//   inserts value before the first entry not less than it, mode 1 removes
//   the earliest entry equal to value
// output channel (out_valid/out_ready): one beat per input beat, giving
//   status, entry count after the operation, and the smallest entry
// every operation finishes in the cycle it is accepted: all cells compare
//   against the broadcast value and shift left or right together, and the
//   result is captured in the output register at the end of that cycle
// throughput is one beat per cycle while the receiver keeps up; the
//   output register is the only buffer, so a new beat is taken when it is
//   empty or being drained in the same cycle
// when the receiver stalls, the result is held and in_ready drops until
//   the result is taken; no state changes meanwhile
// reset empties the list (count cleared) and drops out_valid; the entry
//   registers themselves are not cleared, cells above the count are never
//   read
`include "sorted_byte_list_insert_delete_defines.svh"

module sorted_byte_list_insert_delete #(
	parameter int DEPTH = sbl_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           mode,
	input  logic signed [7:0]              value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     status,
	output logic [$clog2(DEPTH+1)-1:0]     entry_count,
	output logic signed [7:0]              head_value,
	output logic                           head_valid
);

	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	// list state
	logic [CNT_W-1:0]  count_q;

	// output register
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [CNT_W-1:0]  entry_count_q;
	logic signed [7:0] head_value_q;
	logic              head_valid_q;

	// cell row wiring
	logic signed [7:0] cell_value [DEPTH];
	logic signed [7:0] cell_next  [DEPTH];
	logic              cell_lt    [DEPTH];
	logic [DEPTH-1:0]  cell_eq_first;

	logic              in_acc;
	logic              full;
	logic              empty;
	logic              found;
	logic              is_insert;
	sbl_pkg::cell_op_t op;
	logic [CNT_W-1:0]  count_next;
	sbl_pkg::status_t  status_next;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign full      = count_q == DEPTH_C;
	assign empty     = count_q == '0;
	assign found     = |cell_eq_first;
	assign is_insert = mode == sbl_pkg::MODE_INSERT;

	// one operation broadcast to the whole row
	assign op.ins   = in_acc && is_insert && !full;
	assign op.del   = in_acc && !is_insert && found;
	assign op.value = value;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [7:0] left_v;
		logic              left_l;
		logic signed [7:0] right_v;

		if (i == 0) begin : g_first
			// nothing to the left: behaves as a smaller neighbour
			assign left_v = value;
			assign left_l = 1'b1;
		end else begin : g_mid
			assign left_v = cell_value[i-1];
			assign left_l = cell_lt[i-1];
		end

		if (i == DEPTH-1) begin : g_last
			assign right_v = cell_value[i];
		end else begin : g_inner
			assign right_v = cell_value[i+1];
		end

		sbl_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk         (clk),
			.count       (count_q),
			.op          (op),
			.left_value  (left_v),
			.left_lt     (left_l),
			.right_value (right_v),
			.value       (cell_value[i]),
			.next_value  (cell_next[i]),
			.lt          (cell_lt[i]),
			.eq_first    (cell_eq_first[i])
		);
	end

	always_comb begin
		count_next = count_q;
		if (op.ins) begin
			count_next = count_q + 1'b1;
		end else if (op.del) begin
			count_next = count_q - 1'b1;
		end
	end

	always_comb begin
		if (is_insert) begin
			if (full) begin
				status_next = sbl_pkg::ST_FULL;
			end else begin
				status_next = sbl_pkg::ST_INSERTED;
			end
		end else if (empty) begin
			status_next = sbl_pkg::ST_EMPTY;
		end else if (found) begin
			status_next = sbl_pkg::ST_DELETED;
		end else begin
			status_next = sbl_pkg::ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with each accepted beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q      <= status_next;
			entry_count_q <= count_next;
			head_valid_q  <= count_next != '0;
			head_value_q  <= (count_next != '0) ? cell_next[0] : 8'sd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign head_value  = head_value_q;
	assign head_valid  = head_valid_q;

	// count stays within the row
	`SBL_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q <= DEPTH_C)
	// a successful insert grows the list by one
	`SBL_ASSERT_NEXT(a_insert_grows, clk, arst_n, op.ins, count_q == $past(count_q) + 1'b1)
	// a successful delete shrinks the list by one
	`SBL_ASSERT_NEXT(a_delete_shrinks, clk, arst_n, op.del, count_q == $past(count_q) - 1'b1)
	// head flag agrees with the reported count
	`SBL_ASSERT_NOW(a_head_flag, clk, arst_n, out_valid_q, head_valid_q == (entry_count_q != '0))

endmodule

// ----- rtl/sbl_cell.sv -----
// one cell of the sorted list: an entry, its compare and its shift mux
module sbl_cell #(
	parameter int DEPTH = sbl_pkg::DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                           clk,
	input  logic [$clog2(DEPTH+1)-1:0]     count,
	input  sbl_pkg::cell_op_t              op,
	input  logic signed [7:0]              left_value,
	input  logic                           left_lt,
	input  logic signed [7:0]              right_value,
	output logic signed [7:0]              value,
	output logic signed [7:0]              next_value,
	output logic                           lt,
	output logic                           eq_first
);

	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic signed [7:0] entry_q;
	logic              occupied;

	assign occupied = IDX_C < count;
	assign value    = entry_q;
	// entry strictly below the operand
	assign lt       = occupied && (entry_q < op.value);
	// earliest equal entry: everything to the left is smaller
	assign eq_first = occupied && (entry_q == op.value) && left_lt;

	always_comb begin
		next_value = entry_q;
		if (op.ins) begin
			if (!lt) begin
				next_value = left_lt ? op.value : left_value;
			end
		end else if (op.del) begin
			if (!lt) begin
				next_value = right_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= next_value;
	end

endmodule
